@@ rtl/mtbr_pkg.sv @@
package mtbr_pkg;

    localparam int TABLE_WORDS = 624;
    localparam int ADDR_W      = 10;

    localparam logic [ADDR_W-1:0] LAST_INDEX   = ADDR_W'(TABLE_WORDS - 1);
    localparam logic [ADDR_W-1:0] FULL_POS     = ADDR_W'(TABLE_WORDS);
    localparam logic [ADDR_W-1:0] SHIFT_OFFSET = ADDR_W'(397);
    localparam logic [ADDR_W-1:0] WRAP_OFFSET  = ADDR_W'(TABLE_WORDS - 397);

    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam logic [31:0] TWIST_MAG  = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc60000;
    localparam logic [31:0] UPPER_MASK = 32'h80000000;
    localparam logic [31:0] LOWER_MASK = 32'h7fffffff;
    localparam logic [31:0] RESET_SEED = 32'd5489;

    localparam logic [1:0] MODE_RAW     = 2'd0;
    localparam logic [1:0] MODE_BOUNDED = 2'd1;
    localparam logic [1:0] MODE_RESEED  = 2'd2;

    typedef enum logic [1:0] {
        OP_SEED   = 2'd0,
        OP_TWIST  = 2'd1,
        OP_TEMPER = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       c;
        logic [ADDR_W-1:0] idx;
    } t_unit_req;

endpackage

@@ rtl/mtbr_if.sv @@
interface mtbr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] bound;

    modport source (output valid, output mode, output bound, input ready);
    modport sink (input valid, input mode, input bound, output ready);
endinterface

interface mtbr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

@@ rtl/mtbr_word_ram.sv @@
module mtbr_word_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [mtbr_pkg::ADDR_W-1:0]   i_waddr,
    input  logic [31:0]                   i_wdata,
    input  logic [mtbr_pkg::ADDR_W-1:0]   i_raddr_a,
    input  logic [mtbr_pkg::ADDR_W-1:0]   i_raddr_b,
    output logic [31:0]                   o_rdata_a,
    output logic [31:0]                   o_rdata_b
);

    logic [31:0] r_mem [mtbr_pkg::TABLE_WORDS];
    logic [31:0] r_rdata_a;
    logic [31:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/mtbr_unit.sv @@
module mtbr_unit (
    input  mtbr_pkg::t_unit_req i_req,
    output logic [31:0]         o_result
);

    logic [31:0] folded;
    logic [31:0] product;
    logic [31:0] mixed;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;

    always_comb begin
        folded  = i_req.a ^ (i_req.a >> 30);
        product = mtbr_pkg::SEED_MULT * folded;
        mixed   = (i_req.a & mtbr_pkg::UPPER_MASK) | (i_req.b & mtbr_pkg::LOWER_MASK);
        t1      = i_req.a ^ (i_req.a >> 11);
        t2      = t1 ^ ((t1 << 7) & mtbr_pkg::TEMPER_B);
        t3      = t2 ^ ((t2 << 15) & mtbr_pkg::TEMPER_C);
        case (i_req.op)
            mtbr_pkg::OP_SEED: begin
                o_result = product + 32'(i_req.idx);
            end
            mtbr_pkg::OP_TWIST: begin
                o_result = i_req.c ^ (mixed >> 1)
                         ^ (mixed[0] ? mtbr_pkg::TWIST_MAG : 32'd0);
            end
            mtbr_pkg::OP_TEMPER: begin
                o_result = t3 ^ (t3 >> 18);
            end
            default: begin
                o_result = 32'd0;
            end
        endcase
    end

endmodule

@@ rtl/mt19937_bounded_random.sv @@
// MT19937 generator with bounded draws. Requests arrive as words on i_req and
// are taken only while the block is idle; a raw or bounded draw returns one word
// on o_rsp, a reseed returns nothing. A draw reads a table word and tempers it;
// each rejected word of a bounded draw reads and tempers the next word. When the
// 624-word table is exhausted the next draw first twists it, a read state and a
// write state per word on the dual-read table memory. A reseed, or the first draw
// after reset, fills the table, one multiply a cycle.
module mt19937_bounded_random (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_data,
    mtbr_req_if.sink        i_req,
    mtbr_rsp_if.source      o_rsp
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SEED  = 7'b0000010,
        ST_DRAW  = 7'b0000100,
        ST_TW_RD = 7'b0001000,
        ST_TW_WR = 7'b0010000,
        ST_CHECK = 7'b0100000,
        ST_PUSH  = 7'b1000000
    } t_state;

    localparam int AW = mtbr_pkg::ADDR_W;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_idx, n_idx;
    logic [AW-1:0]  r_pos, n_pos;
    logic           r_seeded, n_seeded;
    logic           r_pend, n_pend;
    logic           r_bounded, n_bounded;
    logic [31:0]    r_seed;
    logic [31:0]    r_bound, n_bound;
    logic [31:0]    r_mask, n_mask;
    logic [31:0]    r_p, n_p;
    logic [31:0]    r_cur, n_cur;
    logic [31:0]    r_result, n_result;
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_out_data, n_out_data;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [31:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr_a;
    logic [AW-1:0]  ram_raddr_b;
    logic [31:0]    q_a;
    logic [31:0]    q_b;

    mtbr_pkg::t_unit_req unit_req;
    logic [31:0]         unit_res;
    logic [31:0]         smear;
    logic [31:0]         masked;

    mtbr_word_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (q_a),
        .o_rdata_b (q_b)
    );

    mtbr_unit u_unit (
        .i_req    (unit_req),
        .o_result (unit_res)
    );

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.random_value = r_out_data;

    always_comb begin
        smear = i_req.bound;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
    end

    assign masked = r_bounded ? (unit_res & r_mask) : unit_res;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_seeded    = r_seeded;
        n_pend      = r_pend;
        n_bounded   = r_bounded;
        n_bound     = r_bound;
        n_mask      = r_mask;
        n_p         = r_p;
        n_cur       = r_cur;
        n_result    = r_result;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        n_out_data  = r_out_data;

        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = unit_res;
        ram_raddr_a = '0;
        ram_raddr_b = '0;

        unit_req.op  = mtbr_pkg::OP_TEMPER;
        unit_req.a   = q_a;
        unit_req.b   = q_a;
        unit_req.c   = q_b;
        unit_req.idx = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.mode)
                        mtbr_pkg::MODE_RESEED: begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = r_seed;
                            n_p       = r_seed;
                            n_idx     = AW'(1);
                            n_pend    = 1'b0;
                            n_state   = ST_SEED;
                        end
                        mtbr_pkg::MODE_RAW, mtbr_pkg::MODE_BOUNDED: begin
                            n_bounded = (i_req.mode == mtbr_pkg::MODE_BOUNDED);
                            n_bound   = i_req.bound;
                            n_mask    = smear;
                            if (!r_seeded) begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = r_seed;
                                n_p       = r_seed;
                                n_idx     = AW'(1);
                                n_pend    = 1'b1;
                                n_state   = ST_SEED;
                            end else begin
                                n_state = ST_DRAW;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEED: begin
                unit_req.op = mtbr_pkg::OP_SEED;
                unit_req.a  = r_p;
                ram_we      = 1'b1;
                n_p         = unit_res;
                if (r_idx == mtbr_pkg::LAST_INDEX) begin
                    n_seeded = 1'b1;
                    n_pos    = mtbr_pkg::FULL_POS;
                    n_state  = r_pend ? ST_DRAW : ST_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_DRAW: begin
                if (r_pos == mtbr_pkg::FULL_POS) begin
                    ram_raddr_a = '0;
                    n_idx       = '0;
                    n_state     = ST_TW_RD;
                end else begin
                    ram_raddr_a = r_pos;
                    n_pos       = r_pos + AW'(1);
                    n_state     = ST_CHECK;
                end
            end
            ST_TW_RD: begin
                if (r_idx == '0) begin
                    n_cur = q_a;
                end
                ram_raddr_a = (r_idx == mtbr_pkg::LAST_INDEX) ? '0 : r_idx + AW'(1);
                ram_raddr_b = (r_idx < mtbr_pkg::WRAP_OFFSET)
                            ? r_idx + mtbr_pkg::SHIFT_OFFSET
                            : r_idx - mtbr_pkg::WRAP_OFFSET;
                n_state     = ST_TW_WR;
            end
            ST_TW_WR: begin
                unit_req.op = mtbr_pkg::OP_TWIST;
                unit_req.a  = r_cur;
                unit_req.b  = q_a;
                unit_req.c  = q_b;
                ram_we      = 1'b1;
                n_cur       = q_a;
                if (r_idx == mtbr_pkg::LAST_INDEX) begin
                    n_pos   = '0;
                    n_state = ST_DRAW;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = ST_TW_RD;
                end
            end
            ST_CHECK: begin
                unit_req.op = mtbr_pkg::OP_TEMPER;
                unit_req.a  = q_a;
                if (!r_bounded || (masked <= r_bound)) begin
                    n_result = masked;
                    n_state  = ST_PUSH;
                end else begin
                    n_state = ST_DRAW;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_result;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= mtbr_pkg::FULL_POS;
            r_seeded    <= 1'b0;
            r_pend      <= 1'b0;
            r_seed      <= mtbr_pkg::RESET_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_seeded    <= n_seeded;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_bounded  <= n_bounded;
        r_bound    <= n_bound;
        r_mask     <= n_mask;
        r_p        <= n_p;
        r_cur      <= n_cur;
        r_result   <= n_result;
        r_out_data <= n_out_data;
    end

endmodule
